// ----- hdl/mjq_pkg.sv -----
// Shared constants and types for the minimum-jerk quintic coefficient block.
`default_nettype none

package mjq_pkg;

    // Field widths.
    localparam int DUR_W = 12;
    localparam int IN_W  = 32;
    localparam int OUT_W = 48;
    localparam int NUM_W = 64;

    // Quotient bits kept by the dividers and the divider pipeline depth.
    localparam int QUO_W   = 49;
    localparam int DIV_LAT = QUO_W + 3;

    // Divisor widths for T^3, T^4 and T^5, and the scale shift of each numerator.
    localparam int D3_W = 3 * DUR_W;
    localparam int D4_W = 4 * DUR_W;
    localparam int D5_W = 5 * DUR_W;
    localparam int SH3  = 23;
    localparam int SH4  = 31;
    localparam int SH5  = 39;

    // Reset value of the duration register (2.5 s in units of 1/256 s).
    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(640);

    // Clipping limits of a signed 48-bit magnitude.
    localparam logic [QUO_W-1:0] LIM_POS = QUO_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(48'h7FFF_FFFF_FFFF) + QUO_W'(1);

    // Lower coefficients carried alongside the dividers.
    typedef struct packed {
        logic signed [IN_W-1:0] sp;
        logic signed [IN_W-1:0] sv;
        logic signed [IN_W-1:0] sa;
    } low_t;

    // One finished result item.
    typedef struct packed {
        logic [OUT_W-1:0] coef0;
        logic [OUT_W-1:0] coef1;
        logic [OUT_W-1:0] coef2;
        logic [OUT_W-1:0] coef3;
        logic [OUT_W-1:0] coef4;
        logic [OUT_W-1:0] coef5;
        logic             saturated;
    } res_t;

endpackage

`default_nettype wire

// ----- hdl/mjq_divider.sv -----
// Pipelined restoring divider: rounded, saturated (|num| * 2^SH) / dvs with sign.
`default_nettype none

module mjq_divider #(
    parameter int DW = 36,
    parameter int SH = 23
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [mjq_pkg::NUM_W-1:0] num,
    input  wire logic [DW-1:0]                 dvs,
    output logic [mjq_pkg::OUT_W-1:0]          quo,
    output logic                               sat
);
    import mjq_pkg::*;

    localparam int NW = NUM_W + SH + 1;
    localparam int TW = NW - QUO_W;
    localparam int CW = (TW > DW) ? TW : DW;

    // Prepare stage: magnitude, scale and add half the divisor for rounding.
    logic [NUM_W-1:0] a_mag;
    logic [NW-1:0]    a_n_next;
    logic [NW-1:0]    a_n_reg;
    logic             a_neg_reg;
    logic [DW-1:0]    a_dvs_reg;

    always_comb begin
        a_mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        a_n_next = {1'b0, a_mag, {SH{1'b0}}} + NW'(dvs >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_n_reg   <= a_n_next;
            a_neg_reg <= num[NUM_W-1];
            a_dvs_reg <= dvs;
        end
    end

    // Range stage: the quotient is too large when the upper dividend part reaches the divisor.
    logic [CW-1:0]    b_top;
    logic [DW-1:0]    r_reg   [0:QUO_W-1];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic [QUO_W-1:0] lo_reg  [0:QUO_W-1];
    logic [DW-1:0]    dvs_reg [0:QUO_W-1];
    logic             big_reg [0:QUO_W];
    logic             neg_reg [0:QUO_W];

    assign b_top = CW'(a_n_reg[NW-1:QUO_W]);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= DW'(b_top);
            q_reg[0]   <= '0;
            lo_reg[0]  <= a_n_reg[QUO_W-1:0];
            dvs_reg[0] <= a_dvs_reg;
            big_reg[0] <= (b_top >= CW'(a_dvs_reg));
            neg_reg[0] <= a_neg_reg;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DW:0] rin;
        logic [DW:0] rsub;
        logic        ge;

        always_comb begin
            rin  = {r_reg[k-1], lo_reg[k-1][QUO_W-1]};
            ge   = (rin >= {1'b0, dvs_reg[k-1]});
            rsub = rin - {1'b0, dvs_reg[k-1]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]   <= {q_reg[k-1][QUO_W-2:0], ge};
                big_reg[k] <= big_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end

        // The remainder, divisor and low dividend bits are needed by later stages only.
        if (k < QUO_W) begin : g_lo
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k]   <= ge ? rsub[DW-1:0] : rin[DW-1:0];
                    dvs_reg[k] <= dvs_reg[k-1];
                    lo_reg[k]  <= {lo_reg[k-1][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output stage: clip to the 48-bit range and restore the sign.
    logic [QUO_W-1:0] c_lim;
    logic [QUO_W-1:0] c_q;
    logic             sat_next;
    logic [OUT_W-1:0] quo_next;
    logic [OUT_W-1:0] quo_reg;
    logic             sat_reg;

    always_comb begin
        c_lim    = neg_reg[QUO_W] ? LIM_NEG : LIM_POS;
        sat_next = big_reg[QUO_W] || (q_reg[QUO_W] > c_lim);
        c_q      = sat_next ? c_lim : q_reg[QUO_W];
        quo_next = neg_reg[QUO_W] ? OUT_W'(-c_q) : OUT_W'(c_q);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// ----- hdl/min_jerk_quintic_coeffs_core.sv -----
// Top level: minimum-jerk quintic coefficients from start and end states.
//
//   Port group   Dir  Handshake          Contents
//   s_*          in   s_valid / s_ready  start and end position, velocity, acceleration
//   m_*          out  m_valid / m_ready  coef0..coef5 (Q16.32) and saturated flag
//   cfg_*        in   cfg_we             duration, 1/256 s units
//
// One item per cycle is accepted while s_ready is high. From the accepting edge to
// m_valid an item passes four setup stages after capture, the 52-stage bit-per-stage
// dividers and the write into the output queue.
// Synchronous active-low reset clears the valid bits, the output queue and sets
// duration to 640. A two-entry output queue lets the pipeline keep moving while one
// result waits; the whole pipeline holds only when the queue is full.
`default_nettype none

module min_jerk_quintic_coeffs_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [mjq_pkg::DUR_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [mjq_pkg::IN_W-1:0]  s_start_pos,
    input  wire logic signed [mjq_pkg::IN_W-1:0]  s_start_vel,
    input  wire logic signed [mjq_pkg::IN_W-1:0]  s_start_acc,
    input  wire logic signed [mjq_pkg::IN_W-1:0]  s_end_pos,
    input  wire logic signed [mjq_pkg::IN_W-1:0]  s_end_vel,
    input  wire logic signed [mjq_pkg::IN_W-1:0]  s_end_acc,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [mjq_pkg::OUT_W-1:0]   m_coef0,
    output logic signed [mjq_pkg::OUT_W-1:0]   m_coef1,
    output logic signed [mjq_pkg::OUT_W-1:0]   m_coef2,
    output logic signed [mjq_pkg::OUT_W-1:0]   m_coef3,
    output logic signed [mjq_pkg::OUT_W-1:0]   m_coef4,
    output logic signed [mjq_pkg::OUT_W-1:0]   m_coef5,
    output logic                               m_saturated
);
    import mjq_pkg::*;

    // Duration register.
    logic [DUR_W-1:0] dur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg <= DUR_RESET;
        end else if (cfg_we) begin
            dur_reg <= cfg_wdata;
        end
    end

    // Pipeline advance: everything moves unless the output queue is full.
    logic [1:0] cnt_reg;
    logic       en;

    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    // Valid bits for the setup stages and the divider span.
    logic [4:0]         vld_reg;
    logic [DIV_LAT-1:0] vdly_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            vdly_reg <= '0;
        end else if (en) begin
            vld_reg  <= {vld_reg[3:0], s_valid};
            vdly_reg <= {vdly_reg[DIV_LAT-2:0], vld_reg[4]};
        end
    end

    // Stage 1: capture the item and the effective duration (zero acts as one).
    logic signed [IN_W-1:0] s1_sp_reg, s1_sv_reg, s1_sa_reg;
    logic signed [IN_W-1:0] s1_ep_reg, s1_ev_reg, s1_ea_reg;
    logic [DUR_W-1:0]       s1_d_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sp_reg <= s_start_pos;
            s1_sv_reg <= s_start_vel;
            s1_sa_reg <= s_start_acc;
            s1_ep_reg <= s_end_pos;
            s1_ev_reg <= s_end_vel;
            s1_ea_reg <= s_end_acc;
            s1_d_reg  <= (dur_reg == '0) ? DUR_W'(1) : dur_reg;
        end
    end

    // Stage 2: first products by T and the raw differences.
    logic signed [44:0]      s2_svd_reg, s2_sad_reg;
    logic [2*DUR_W-1:0]      s2_d2_reg;
    logic signed [32:0]      s2_dp_reg, s2_dvr_reg, s2_da_reg;
    logic [DUR_W-1:0]        s2_d_reg;
    low_t                    s2_low_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_svd_reg <= 45'(s1_sv_reg) * 45'($signed({1'b0, s1_d_reg}));
            s2_sad_reg <= 45'(s1_sa_reg) * 45'($signed({1'b0, s1_d_reg}));
            s2_d2_reg  <= (2*DUR_W)'(s1_d_reg) * (2*DUR_W)'(s1_d_reg);
            s2_dp_reg  <= 33'(s1_ep_reg) - 33'(s1_sp_reg);
            s2_dvr_reg <= 33'(s1_ev_reg) - 33'(s1_sv_reg);
            s2_da_reg  <= 33'(s1_ea_reg) - 33'(s1_sa_reg);
            s2_d_reg   <= s1_d_reg;
            s2_low_reg <= '{sp: s1_sp_reg, sv: s1_sv_reg, sa: s1_sa_reg};
        end
    end

    // Stage 3: a0*T^2, T^3 and the velocity defect dv (scaled by 2^24).
    logic signed [56:0]  s3_sad2_reg;
    logic [D3_W-1:0]     s3_d3_reg;
    logic signed [45:0]  s3_dv_reg;
    logic signed [32:0]  s3_dp_reg, s3_da_reg;
    logic signed [44:0]  s3_svd_reg;
    logic [DUR_W-1:0]    s3_d_reg;
    logic [2*DUR_W-1:0]  s3_d2_reg;
    low_t                s3_low_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sad2_reg <= 57'(s2_low_reg.sa) * 57'($signed({1'b0, s2_d2_reg}));
            s3_d3_reg   <= D3_W'(s2_d2_reg) * D3_W'(s2_d_reg);
            s3_dv_reg   <= (46'(s2_dvr_reg) <<< 8) - 46'(s2_sad_reg);
            s3_dp_reg   <= s2_dp_reg;
            s3_da_reg   <= s2_da_reg;
            s3_svd_reg  <= s2_svd_reg;
            s3_d_reg    <= s2_d_reg;
            s3_d2_reg   <= s2_d2_reg;
            s3_low_reg  <= s2_low_reg;
        end
    end

    // Stage 4: position defect h (scaled by 2^33), dv*T, da*T^2 and T^4.
    logic signed [58:0]  s4_h_reg, s4_dvd_reg;
    logic signed [57:0]  s4_dad2_reg;
    logic [D3_W-1:0]     s4_d3_reg;
    logic [D4_W-1:0]     s4_d4_reg;
    logic [DUR_W-1:0]    s4_d_reg;
    low_t                s4_low_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_h_reg    <= (59'(s3_dp_reg) <<< 17) - (59'(s3_svd_reg) <<< 9)
                           - 59'(s3_sad2_reg);
            s4_dvd_reg  <= 59'(s3_dv_reg) * 59'($signed({1'b0, s3_d_reg}));
            s4_dad2_reg <= 58'(s3_da_reg) * 58'($signed({1'b0, s3_d2_reg}));
            s4_d3_reg   <= s3_d3_reg;
            s4_d4_reg   <= D4_W'(s3_d3_reg) * D4_W'(s3_d_reg);
            s4_d_reg    <= s3_d_reg;
            s4_low_reg  <= s3_low_reg;
        end
    end

    // Stage 5: the three numerators by shifts and adds, and T^5.
    logic signed [NUM_W-1:0] hx, dvdx, dadx;
    logic signed [NUM_W-1:0] s5_n3_reg, s5_n4_reg, s5_n5_reg;
    logic [D3_W-1:0]         s5_d3_reg;
    logic [D4_W-1:0]         s5_d4_reg;
    logic [D5_W-1:0]         s5_d5_reg;
    low_t                    s5_low_reg;

    always_comb begin
        hx   = NUM_W'(s4_h_reg);
        dvdx = NUM_W'(s4_dvd_reg);
        dadx = NUM_W'(s4_dad2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_n3_reg  <= (hx <<< 3) + (hx <<< 1) - (dvdx <<< 3) + dadx;
            s5_n4_reg  <= hx - (hx <<< 4) + (dvdx <<< 4) - (dvdx <<< 1) - (dadx <<< 1);
            s5_n5_reg  <= (hx <<< 2) + (hx <<< 1) - (dvdx <<< 2) - (dvdx <<< 1) + dadx;
            s5_d3_reg  <= s4_d3_reg;
            s5_d4_reg  <= s4_d4_reg;
            s5_d5_reg  <= D5_W'(s4_d4_reg) * D5_W'(s4_d_reg);
            s5_low_reg <= s4_low_reg;
        end
    end

    // Dividers for the upper three coefficients.
    logic [OUT_W-1:0] q3, q4, q5;
    logic             sat3, sat4, sat5;

    mjq_divider #(.DW(D3_W), .SH(SH3)) u_div3 (
        .aclk (aclk), .en (en), .num (s5_n3_reg), .dvs (s5_d3_reg),
        .quo  (q3),   .sat (sat3)
    );

    mjq_divider #(.DW(D4_W), .SH(SH4)) u_div4 (
        .aclk (aclk), .en (en), .num (s5_n4_reg), .dvs (s5_d4_reg),
        .quo  (q4),   .sat (sat4)
    );

    mjq_divider #(.DW(D5_W), .SH(SH5)) u_div5 (
        .aclk (aclk), .en (en), .num (s5_n5_reg), .dvs (s5_d5_reg),
        .quo  (q5),   .sat (sat5)
    );

    // Lower coefficients wait alongside the dividers.
    low_t dly_reg [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= s5_low_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    // Assemble the finished item.
    res_t res;
    low_t low_out;

    always_comb begin
        low_out         = dly_reg[DIV_LAT-1];
        res.coef0       = {low_out.sp, 16'b0};
        res.coef1       = {low_out.sv, 16'b0};
        res.coef2       = {low_out.sa[IN_W-1], low_out.sa, 15'b0};
        res.coef3       = q3;
        res.coef4       = q4;
        res.coef5       = q5;
        res.saturated   = sat3 | sat4 | sat5;
    end

    // Two-entry output queue.
    res_t       fifo_mem [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    assign push = en && vdly_reg[DIV_LAT-1];
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Result channel.
    res_t head;

    assign head        = fifo_mem[rd_ptr_reg];
    assign m_valid     = (cnt_reg != 2'd0);
    assign m_coef0     = head.coef0;
    assign m_coef1     = head.coef1;
    assign m_coef2     = head.coef2;
    assign m_coef3     = head.coef3;
    assign m_coef4     = head.coef4;
    assign m_coef5     = head.coef5;
    assign m_saturated = head.saturated;

endmodule

`default_nettype wire
